/* rtl/core/pun_pkg.sv */
package pun_pkg;

   localparam int MAX_ROW_BYTES_DEF   = 8192;
   localparam int MAX_PIXEL_BYTES_DEF = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_STRIDE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_ROWS   = 2'd2;

   localparam int ROW_LENGTH_W   = 14;
   localparam int PIXEL_STRIDE_W = 3;
   localparam int IMAGE_ROWS_W   = 16;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

endpackage

/* rtl/core/png_scanline_unfilter.sv */
// A sample request passes through stage 1, where the line store read lands, and then
// the output register; a stalled response channel can hold it in stage 1.
// Throughput: one byte per cycle while the response is not stalled, set by the single
// read port and single write port of the line store, which are both used once per sample.
// Reset is synchronous and active high; it clears the row state, histories and
// configuration (all registers to 1). The line store is not cleared.
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = pun_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pun_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // csr port
   input  logic                               csr_wr_en,
   input  logic [pun_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pun_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pun_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] raw_byte
   input  logic [pun_pkg::REQ_USER_W-1:0]     req_tuser,  // [0] image_start
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pun_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [7:0] sample
   output logic                               rsp_tlast,  // row_done
   output logic [pun_pkg::RSP_USER_W-1:0]     rsp_tuser   // [0] image_done, [1] bad_filter
);
   import pun_pkg::*;

   localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int LW = 17;
   localparam logic [LW-1:0] MAX_LEN    = LW'(MAX_ROW_BYTES);
   localparam logic [3:0]    MAX_STRIDE = 4'(MAX_PIXEL_BYTES);

   // configuration
   logic [ROW_LENGTH_W-1:0]   row_length_ff;
   logic [PIXEL_STRIDE_W-1:0] pixel_stride_ff;
   logic [IMAGE_ROWS_W-1:0]   image_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff   <= ROW_LENGTH_W'(1);
         pixel_stride_ff <= PIXEL_STRIDE_W'(1);
         image_rows_ff   <= IMAGE_ROWS_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_LENGTH:   row_length_ff   <= csr_wdata[ROW_LENGTH_W-1:0];
            CSR_PIXEL_STRIDE: pixel_stride_ff <= csr_wdata[PIXEL_STRIDE_W-1:0];
            CSR_IMAGE_ROWS:   image_rows_ff   <= csr_wdata[IMAGE_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   logic [LW-1:0]           len_raw;
   logic [LW-1:0]           len_eff;
   logic [3:0]              stride_raw;
   logic [3:0]              stride_eff;
   logic [IMAGE_ROWS_W-1:0] rows_eff;

   always_comb begin
      len_raw    = (row_length_ff == '0) ? LW'(1) : LW'(row_length_ff);
      len_eff    = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
      stride_raw = (pixel_stride_ff == '0) ? 4'd1 : 4'(pixel_stride_ff);
      stride_eff = (stride_raw > MAX_STRIDE) ? MAX_STRIDE : stride_raw;
      rows_eff   = (image_rows_ff == '0) ? IMAGE_ROWS_W'(1) : image_rows_ff;
   end

   // row control state
   logic [AW-1:0]           col_ff, col_in;
   logic [IMAGE_ROWS_W-1:0] row_ff, row_in;
   filter_type              kind_ff, kind_in;
   logic                    awaiting_ff, awaiting_in;
   logic                    first_ff, first_in;
   logic                    halted_ff, halted_in;
   // column modulo every possible stride, so the history slot needs no divider
   logic [SW-1:0]           mod_ff [MAX_PIXEL_BYTES];
   logic [SW-1:0]           mod_in [MAX_PIXEL_BYTES];

   logic                    accept;
   logic                    start;
   logic [AW-1:0]           e_col;
   logic [IMAGE_ROWS_W-1:0] e_row;
   filter_type              e_kind;
   logic                    e_awaiting, e_first, e_halted;
   logic [SW-1:0]           e_mod [MAX_PIXEL_BYTES];
   logic [SW-1:0]           stride_sel;
   logic                    p_sample, p_bad, p_last, p_img;

   assign accept     = req_tvalid & req_tready;
   assign start      = req_tuser[0];
   assign stride_sel = SW'(stride_eff - 4'd1);

   always_comb begin
      e_col      = start ? '0 : col_ff;
      e_row      = start ? '0 : row_ff;
      e_kind     = start ? FILT_NONE : kind_ff;
      e_awaiting = start | awaiting_ff;
      e_first    = start | first_ff;
      e_halted   = ~start & halted_ff;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
         e_mod[k] = start ? '0 : mod_ff[k];
      end

      col_in      = e_col;
      row_in      = e_row;
      kind_in     = e_kind;
      awaiting_in = e_awaiting;
      first_in    = e_first;
      halted_in   = e_halted;
      mod_in      = e_mod;
      p_sample    = 1'b0;
      p_bad       = 1'b0;
      p_last      = 1'b0;
      p_img       = 1'b0;

      if (e_halted || (e_row >= rows_eff)) begin
         // Past the last row or after a bad filter byte: dropped.
      end else if (e_awaiting) begin
         if (req_tdata > REQ_DATA_W'(FILT_PAETH)) begin
            halted_in = 1'b1;
            p_bad     = 1'b1;
         end else begin
            kind_in     = filter_type'(req_tdata[2:0]);
            awaiting_in = 1'b0;
            col_in      = '0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               mod_in[k] = '0;
            end
         end
      end else begin
         p_sample = 1'b1;
         if ((LW'(e_col) + LW'(1)) >= len_eff) begin
            p_last      = 1'b1;
            col_in      = '0;
            awaiting_in = 1'b1;
            first_in    = 1'b0;
            row_in      = e_row + IMAGE_ROWS_W'(1);
            p_img       = (LW'(e_row) + LW'(1)) >= LW'(rows_eff);
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               mod_in[k] = '0;
            end
         end else begin
            col_in = e_col + AW'(1);
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               mod_in[k] = (e_mod[k] == SW'(k)) ? '0 : e_mod[k] + SW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         kind_ff     <= FILT_NONE;
         awaiting_ff <= 1'b1;
         first_ff    <= 1'b1;
         halted_ff   <= 1'b0;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            mod_ff[k] <= '0;
         end
      end else if (accept) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         kind_ff     <= kind_in;
         awaiting_ff <= awaiting_in;
         first_ff    <= first_in;
         halted_ff   <= halted_in;
         mod_ff      <= mod_in;
      end
   end

   // Stage 1: line store data is back, the sample is rebuilt and written.
   logic                s1_valid_ff;
   logic                s1_clear_ff, s1_sample_ff, s1_bad_ff, s1_last_ff, s1_img_ff;
   logic [AW-1:0]       s1_x_ff;
   logic [SW-1:0]       s1_slot_ff;
   logic                s1_left_ok_ff;
   logic                s1_first_ff;
   filter_type          s1_kind_ff;
   logic [7:0]          s1_byte_ff;
   logic                s1_result;
   logic                s1_adv;
   logic                out_free;

   assign s1_result  = s1_sample_ff | s1_bad_ff;
   assign out_free   = ~rsp_tvalid | rsp_tready;
   assign s1_adv     = s1_valid_ff & (~s1_result | out_free);
   assign req_tready = ~s1_valid_ff | s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_clear_ff   <= start;
         s1_sample_ff  <= p_sample;
         s1_bad_ff     <= p_bad;
         s1_last_ff    <= p_last;
         s1_img_ff     <= p_img;
         s1_x_ff       <= e_col;
         s1_slot_ff    <= e_mod[stride_sel];
         s1_left_ok_ff <= LW'(e_col) >= LW'(stride_eff);
         s1_first_ff   <= e_first;
         s1_kind_ff    <= e_kind;
         s1_byte_ff    <= req_tdata[7:0];
      end
   end

   // previous-row line store
   logic [7:0] line_mem [MAX_ROW_BYTES];
   logic [7:0] line_rd_ff;
   logic       line_wr;
   logic [7:0] v;

   assign line_wr = s1_adv & s1_sample_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[e_col];
      end
   end

   always_ff @(posedge clock) begin
      if (line_wr) begin
         line_mem[s1_x_ff] <= v;
      end
   end

   // left and upper-left histories, one entry per byte of a pixel
   logic [7:0] left_ff [MAX_PIXEL_BYTES];
   logic [7:0] upleft_ff [MAX_PIXEL_BYTES];

   logic [7:0]        nb_a, nb_b, nb_c;
   logic [8:0]        avg_sum;
   logic signed [9:0] pp, pa, pb, pc;
   logic [9:0]        da, db, dc;
   logic [7:0]        paeth;

   always_comb begin
      nb_a = s1_left_ok_ff ? left_ff[s1_slot_ff] : 8'd0;
      nb_b = s1_first_ff ? 8'd0 : line_rd_ff;
      nb_c = (!s1_first_ff && s1_left_ok_ff) ? upleft_ff[s1_slot_ff] : 8'd0;

      avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

      pp = $signed({2'b00, nb_a}) + $signed({2'b00, nb_b}) - $signed({2'b00, nb_c});
      pa = pp - $signed({2'b00, nb_a});
      pb = pp - $signed({2'b00, nb_b});
      pc = pp - $signed({2'b00, nb_c});
      da = pa[9] ? 10'(-pa) : 10'(pa);
      db = pb[9] ? 10'(-pb) : 10'(pb);
      dc = pc[9] ? 10'(-pc) : 10'(pc);
      if (da <= db && da <= dc) begin
         paeth = nb_a;
      end else if (db <= dc) begin
         paeth = nb_b;
      end else begin
         paeth = nb_c;
      end

      case (s1_kind_ff)
         FILT_NONE:  v = s1_byte_ff;
         FILT_SUB:   v = s1_byte_ff + nb_a;
         FILT_UP:    v = s1_byte_ff + nb_b;
         FILT_AVG:   v = s1_byte_ff + avg_sum[8:1];
         FILT_PAETH: v = s1_byte_ff + paeth;
         default:    v = s1_byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]   <= 8'd0;
            upleft_ff[k] <= 8'd0;
         end
      end else if (s1_adv && s1_clear_ff) begin
         // The clear of an image start takes effect in request order.
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]   <= 8'd0;
            upleft_ff[k] <= 8'd0;
         end
      end else if (line_wr) begin
         left_ff[s1_slot_ff]   <= v;
         upleft_ff[s1_slot_ff] <= nb_b;
      end
   end

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_sample_ff;
   logic       rsp_last_ff, rsp_img_ff, rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_result) begin
         rsp_sample_ff <= s1_bad_ff ? 8'd0 : v;
         rsp_last_ff   <= s1_last_ff;
         rsp_img_ff    <= s1_img_ff;
         rsp_bad_ff    <= s1_bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_img_ff};

endmodule

/* rtl/core/pun_checker.sv */
module pun_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [pun_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tlast,
   input logic [pun_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   // The end of an image is always also the end of a row.
   a_image_ends_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("image_done without row_done");

   // A bad filter response carries no sample and no row or image marks.
   a_bad_is_bare: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata == '0 && !rsp_tlast && !rsp_tuser[0]))
      else $error("bad filter response carries data or marks");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // Reset flushes any pending response.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind png_scanline_unfilter pun_checker u_pun_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
